/* rtl/vtpd_pkg.sv */
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared widths, reset values, register indexes and lane types for the vertex
// transform with perspective divide.
// ----------------------------------------------------------------------------
package vtpd_pkg;

	localparam int VW         = 32;       // Q16.16 vertex component
	localparam int CW         = 16;       // Q4.12 coefficient
	localparam int PW         = VW + CW;  // exact product, Q.28
	localparam int SW         = 50;       // signed dot product sum, Q.28
	localparam int MW         = SW - 1;   // magnitude of a sum
	localparam int QW         = 32;       // quotient bits, Q16.16
	localparam int FRAC       = 16;       // fraction bits of a quotient
	localparam int DIV_STAGES = QW;       // one quotient bit per stage
	localparam int NCOL       = 4;
	localparam int NIN        = 3;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DW     = NCOL * CW;
	localparam int ZSHIFT     = 12;       // Q.28 to Q16.16

	localparam logic [CFG_DW-1:0] COLUMN_X_RST = 64'h0000_0000_0000_1000;
	localparam logic [CFG_DW-1:0] COLUMN_Y_RST = 64'h0000_0000_1000_0000;
	localparam logic [CFG_DW-1:0] COLUMN_Z_RST = 64'h0000_1000_0000_0000;
	localparam logic [CFG_DW-1:0] COLUMN_W_RST = 64'h1000_0000_0000_0000;

	localparam logic signed [VW-1:0] SAT_MAX = 32'sh7fff_ffff;
	localparam logic signed [VW-1:0] SAT_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMN_X = 8'd0,
		REG_COLUMN_Y = 8'd1,
		REG_COLUMN_Z = 8'd2,
		REG_COLUMN_W = 8'd3
	} reg_idx_t;

	// operands of one divider lane
	typedef struct packed {
		logic [MW-1:0] a;
		logic [MW-1:0] b;
		logic          neg;
		logic          ovf;
	} div_req_t;

	// result of one divider lane
	typedef struct packed {
		logic [QW-1:0] q;
		logic          neg;
		logic          ovf;
	} div_res_t;

endpackage

/* rtl/vtpd_if.sv */
// ----------------------------------------------------------------------------
// vtpd_if
// Valid/ready channels for vertex words, result words and register writes.
// ----------------------------------------------------------------------------
interface vtpd_in_if;
	logic                         valid;
	logic                         ready;
	logic signed [vtpd_pkg::VW-1:0] vx;
	logic signed [vtpd_pkg::VW-1:0] vy;
	logic signed [vtpd_pkg::VW-1:0] vz;

	modport source (output valid, output vx, output vy, output vz, input ready);
	modport sink (input valid, input vx, input vy, input vz, output ready);
endinterface

interface vtpd_out_if;
	logic                         valid;
	logic                         ready;
	logic signed [vtpd_pkg::VW-1:0] ox;
	logic signed [vtpd_pkg::VW-1:0] oy;
	logic signed [vtpd_pkg::VW-1:0] oz;
	logic                         w_was_zero;
	logic                         saturated;

	modport source (output valid, output ox, output oy, output oz,
		output w_was_zero, output saturated, input ready);
	modport sink (input valid, input ox, input oy, input oz,
		input w_was_zero, input saturated, output ready);
endinterface

interface vtpd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [vtpd_pkg::CFG_IDX_W-1:0]     index;
	logic [vtpd_pkg::CFG_DW-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/vtpd_dot.sv */
// ----------------------------------------------------------------------------
// vtpd_dot
// Two-stage row vector by 4x4 matrix product: products, then column sums.
// ----------------------------------------------------------------------------
module vtpd_dot (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld,
	input  logic signed [vtpd_pkg::VW-1:0]    vx,
	input  logic signed [vtpd_pkg::VW-1:0]    vy,
	input  logic signed [vtpd_pkg::VW-1:0]    vz,
	input  logic [vtpd_pkg::CFG_DW-1:0]       col [vtpd_pkg::NCOL],
	output logic                              vld_s2,
	output logic signed [vtpd_pkg::SW-1:0]    sum_s2 [vtpd_pkg::NCOL]
);

	localparam int PW  = vtpd_pkg::PW;
	localparam int SW  = vtpd_pkg::SW;
	localparam int CW  = vtpd_pkg::CW;
	localparam int NC  = vtpd_pkg::NCOL;
	localparam int NI  = vtpd_pkg::NIN;

	logic                 vld_s1;
	logic signed [PW-1:0] prod_s1 [NC][NI];
	logic signed [CW-1:0] trans_s1 [NC];
	logic signed [vtpd_pkg::VW-1:0] vin [NI];

	assign vin[0] = vx;
	assign vin[1] = vy;
	assign vin[2] = vz;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: exact Q.28 products, hold the translation coefficient
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NC; c++) begin
				for (int i = 0; i < NI; i++) begin
					prod_s1[c][i] <= PW'(vin[i]) * PW'($signed(col[c][i*CW +: CW]));
				end
				trans_s1[c] <= $signed(col[c][NI*CW +: CW]);
			end
		end
	end

	// stage 2: sum the four terms of each column
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NC; c++) begin
				sum_s2[c] <= SW'(prod_s1[c][0]) + SW'(prod_s1[c][1]) + SW'(prod_s1[c][2])
					+ (SW'(trans_s1[c]) <<< vtpd_pkg::FRAC);
			end
		end
	end

endmodule

/* rtl/vtpd_div.sv */
// ----------------------------------------------------------------------------
// vtpd_div
// Pipelined restoring divider, one quotient bit per stage, for one lane.
// ----------------------------------------------------------------------------
module vtpd_div (
	input  logic                clk,
	input  logic                en,
	input  vtpd_pkg::div_req_t  req,
	output vtpd_pkg::div_res_t  res
);

	localparam int MW   = vtpd_pkg::MW;
	localparam int QW   = vtpd_pkg::QW;
	localparam int FR   = vtpd_pkg::FRAC;
	localparam int N    = vtpd_pkg::DIV_STAGES;

	// stage registers
	logic [MW-1:0] rem_s [N];
	logic [QW-1:0] dvd_s [N];
	logic [QW-1:0] quo_s [N];
	logic [MW-1:0] b_s   [N];
	logic          neg_s [N];
	logic          ovf_s [N];

	// stage inputs and next values
	logic [MW-1:0] rem_c [N];
	logic [QW-1:0] dvd_c [N];
	logic [QW-1:0] quo_c [N];
	logic [MW-1:0] b_c   [N];
	logic          neg_c [N];
	logic          ovf_c [N];
	logic [MW:0]   trial [N];
	logic          ge    [N];
	logic [MW-1:0] rem_n [N];

	// select stage inputs and trial subtract
	always_comb begin
		rem_c[0] = {{FR{1'b0}}, req.a[MW-1:FR]};
		dvd_c[0] = {req.a[FR-1:0], {(QW-FR){1'b0}}};
		quo_c[0] = '0;
		b_c[0]   = req.b;
		neg_c[0] = req.neg;
		ovf_c[0] = req.ovf;
		for (int k = 1; k < N; k++) begin
			rem_c[k] = rem_s[k-1];
			dvd_c[k] = dvd_s[k-1];
			quo_c[k] = quo_s[k-1];
			b_c[k]   = b_s[k-1];
			neg_c[k] = neg_s[k-1];
			ovf_c[k] = ovf_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			trial[k] = {rem_c[k], dvd_c[k][QW-1]};
			ge[k]    = trial[k] >= {1'b0, b_c[k]};
			rem_n[k] = ge[k] ? MW'(trial[k] - {1'b0, b_c[k]}) : MW'(trial[k]);
		end
	end

	// advance every stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k] <= rem_n[k];
				dvd_s[k] <= {dvd_c[k][QW-2:0], 1'b0};
				quo_s[k] <= {quo_c[k][QW-2:0], ge[k]};
				b_s[k]   <= b_c[k];
				neg_s[k] <= neg_c[k];
				ovf_s[k] <= ovf_c[k];
			end
		end
	end

	assign res.q   = quo_s[N-1];
	assign res.neg = neg_s[N-1];
	assign res.ovf = ovf_s[N-1];

endmodule

/* rtl/vertex_transform_perspective_divide.sv */
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide
// 4x4 homogeneous transform of a Q16.16 vertex, then divide of x, y, z by w
// with saturation to Q16.16, or the undivided x, y, z when w is zero.
// ----------------------------------------------------------------------------
// Pipeline: 36 register stages (2 multiply/sum, 1 operand, 32 divider, 1 output).
// Throughput: one vertex per cycle while the output is not stalled; the divider takes one quotient bit a stage.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads the identity matrix.
module vertex_transform_perspective_divide (
	input  logic  clk,
	input  logic  arst_n,
	vtpd_in_if.sink    vin,
	vtpd_out_if.source vout,
	vtpd_cfg_if.sink   cfg
);

	localparam int SW = vtpd_pkg::SW;
	localparam int MW = vtpd_pkg::MW;
	localparam int VW = vtpd_pkg::VW;
	localparam int QW = vtpd_pkg::QW;
	localparam int NC = vtpd_pkg::NCOL;
	localparam int NI = vtpd_pkg::NIN;
	localparam int N  = vtpd_pkg::DIV_STAGES;
	localparam int ZS = vtpd_pkg::ZSHIFT;

	logic [vtpd_pkg::CFG_DW-1:0] col_q [NC];
	logic                        en;

	// ---- configuration registers ----
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q[0] <= vtpd_pkg::COLUMN_X_RST;
			col_q[1] <= vtpd_pkg::COLUMN_Y_RST;
			col_q[2] <= vtpd_pkg::COLUMN_Z_RST;
			col_q[3] <= vtpd_pkg::COLUMN_W_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				vtpd_pkg::REG_COLUMN_X: col_q[0] <= cfg.data;
				vtpd_pkg::REG_COLUMN_Y: col_q[1] <= cfg.data;
				vtpd_pkg::REG_COLUMN_Z: col_q[2] <= cfg.data;
				vtpd_pkg::REG_COLUMN_W: col_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---- stall control: hold everything while the output word waits ----
	assign en        = !vout.valid || vout.ready;
	assign vin.ready = en;

	// ---- stages 1 and 2: dot products ----
	logic                 vld_s2;
	logic signed [SW-1:0] sum_s2 [NC];

	vtpd_dot u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (vin.valid),
		.vx     (vin.vx),
		.vy     (vin.vy),
		.vz     (vin.vz),
		.col    (col_q),
		.vld_s2 (vld_s2),
		.sum_s2 (sum_s2)
	);

	// ---- stage 3: magnitudes, overflow test and the undivided path ----
	logic signed [SW-1:0] neg_sum [NC];
	logic [MW-1:0]        mag     [NC];
	logic signed [SW-1:0] zadj    [NI];
	logic signed [SW-1:0] zshr    [NI];
	logic signed [VW-1:0] zval    [NI];
	logic                 zsat;
	logic                 wz;
	vtpd_pkg::div_req_t   req     [NI];

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			neg_sum[c] = -sum_s2[c];
			mag[c]     = sum_s2[c][SW-1] ? MW'(neg_sum[c]) : MW'(sum_s2[c]);
		end
		wz   = (sum_s2[3] == '0);
		zsat = 1'b0;
		for (int i = 0; i < NI; i++) begin
			// truncate toward zero on the way from Q.28 to Q16.16
			zadj[i] = sum_s2[i] + (sum_s2[i][SW-1] ? SW'((1 << ZS) - 1) : SW'(0));
			zshr[i] = zadj[i] >>> ZS;
			if (zshr[i] > SW'(vtpd_pkg::SAT_MAX)) begin
				zval[i] = vtpd_pkg::SAT_MAX;
				zsat    = 1'b1;
			end else if (zshr[i] < SW'(vtpd_pkg::SAT_MIN)) begin
				zval[i] = vtpd_pkg::SAT_MIN;
				zsat    = 1'b1;
			end else begin
				zval[i] = VW'(zshr[i]);
			end
			req[i].a   = mag[i];
			req[i].b   = mag[3];
			req[i].neg = sum_s2[i][SW-1] ^ sum_s2[3][SW-1];
			// integer part of the quotient would need more than 16 bits
			req[i].ovf = {{vtpd_pkg::FRAC{1'b0}}, mag[i][MW-1:vtpd_pkg::FRAC]} >= mag[3];
		end
	end

	logic                 vld_s3;
	vtpd_pkg::div_req_t   req_s3  [NI];
	logic signed [VW-1:0] zval_s3 [NI];
	logic                 zsat_s3;
	logic                 wz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s3  <= req;
			zval_s3 <= zval;
			zsat_s3 <= zsat;
			wz_s3   <= wz;
		end
	end

	// ---- divider lanes ----
	vtpd_pkg::div_res_t res [NI];

	for (genvar g = 0; g < NI; g++) begin : g_div
		vtpd_div u_div (
			.clk (clk),
			.en  (en),
			.req (req_s3[g]),
			.res (res[g])
		);
	end

	// ---- side band travelling beside the divider ----
	logic                 vld_d  [N];
	logic                 wz_d   [N];
	logic                 zsat_d [N];
	logic signed [VW-1:0] zval_d [N][NI];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				vld_d[k] <= 1'b0;
			end
		end else if (en) begin
			vld_d[0] <= vld_s3;
			for (int k = 1; k < N; k++) begin
				vld_d[k] <= vld_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wz_d[0]   <= wz_s3;
			zsat_d[0] <= zsat_s3;
			zval_d[0] <= zval_s3;
			for (int k = 1; k < N; k++) begin
				wz_d[k]   <= wz_d[k-1];
				zsat_d[k] <= zsat_d[k-1];
				zval_d[k] <= zval_d[k-1];
			end
		end
	end

	// ---- output stage: sign, clamp and select the undivided path ----
	logic signed [VW-1:0] qval [NI];
	logic                 qsat;

	always_comb begin
		qsat = 1'b0;
		for (int i = 0; i < NI; i++) begin
			if (res[i].ovf) begin
				qval[i] = res[i].neg ? vtpd_pkg::SAT_MIN : vtpd_pkg::SAT_MAX;
				qsat    = 1'b1;
			end else if (res[i].neg) begin
				if (res[i].q[QW-1] && (res[i].q[QW-2:0] != '0)) begin
					qval[i] = vtpd_pkg::SAT_MIN;
					qsat    = 1'b1;
				end else begin
					qval[i] = VW'(-$signed(res[i].q));
				end
			end else if (res[i].q[QW-1]) begin
				qval[i] = vtpd_pkg::SAT_MAX;
				qsat    = 1'b1;
			end else begin
				qval[i] = $signed(res[i].q);
			end
		end
	end

	logic                 vld_s36;
	logic signed [VW-1:0] o_s36 [NI];
	logic                 wz_s36;
	logic                 sat_s36;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s36 <= 1'b0;
		end else if (en) begin
			vld_s36 <= vld_d[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wz_s36  <= wz_d[N-1];
			sat_s36 <= wz_d[N-1] ? zsat_d[N-1] : qsat;
			o_s36   <= wz_d[N-1] ? zval_d[N-1] : qval;
		end
	end

	assign vout.valid      = vld_s36;
	assign vout.ox         = o_s36[0];
	assign vout.oy         = o_s36[1];
	assign vout.oz         = o_s36[2];
	assign vout.w_was_zero = wz_s36;
	assign vout.saturated  = sat_s36;

	// ---- checks ----
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		vout.valid && vout.saturated |->
			vout.ox == vtpd_pkg::SAT_MAX || vout.ox == vtpd_pkg::SAT_MIN ||
			vout.oy == vtpd_pkg::SAT_MAX || vout.oy == vtpd_pkg::SAT_MIN ||
			vout.oz == vtpd_pkg::SAT_MAX || vout.oz == vtpd_pkg::SAT_MIN)
		else $error("saturated flag without a clamped component");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vout.valid && !vout.ready |=> vout.valid && $stable(vout.ox) &&
			$stable(vout.oy) && $stable(vout.oz) && $stable(vout.w_was_zero) &&
			$stable(vout.saturated))
		else $error("waiting result word changed");

	a_stall_holds_out: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_d[N-1]) && $stable(vld_s3))
		else $error("pipeline advanced while stalled");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!vout.valid |-> vin.ready)
		else $error("input held off with an empty output register");

endmodule
